### hw/rtl/tnsf_pkg.sv
package tnsf_pkg;

  localparam int MAX_TAPS = 20;
  localparam int DATA_W   = 32;
  localparam int TAP_W    = $clog2(MAX_TAPS + 1);
  localparam int ADDR_W   = $clog2(MAX_TAPS);
  localparam int SH_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER = 2'd0,
    REG_SHIFT = 2'd1,
    REG_SCALE = 2'd2
  } reg_idx_t;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic              coef_we;
    logic [ADDR_W-1:0] coef_waddr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              dly_clear;
    logic              dly_push;
  } tap_ctrl_t;

  function automatic word_t sat34(input logic signed [DATA_W+1:0] v);
    word_t r;
    if (v[DATA_W+1:DATA_W-1] == 3'b000 || v[DATA_W+1:DATA_W-1] == 3'b111) begin
      r = v[DATA_W-1:0];
    end else if (v[DATA_W+1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic word_t shl_sat(input word_t a, input logic [SH_W-1:0] n);
    logic signed [2*DATA_W-2:0] w;
    word_t                      r;
    w = (2*DATA_W-1)'(a) <<< n;
    if (w[2*DATA_W-2:DATA_W-1] == {DATA_W{w[2*DATA_W-2]}}) begin
      r = w[DATA_W-1:0];
    end else if (w[2*DATA_W-2]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hw/rtl/tnsf_taps.sv
module tnsf_taps
  import tnsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tap_ctrl_t ctrl,
  input  word_t     coef_wdata,
  input  word_t     push_data,
  output word_t     rd_coef,
  output word_t     rd_dly
);

  word_t coef_mem [MAX_TAPS];
  word_t dly_r    [MAX_TAPS];
  word_t rd_coef_r;
  word_t rd_dly_r;

  always_ff @(posedge clk) begin
    if (ctrl.coef_we) begin
      coef_mem[ctrl.coef_waddr] <= coef_wdata;
    end
    if (ctrl.rd_en) begin
      rd_coef_r <= coef_mem[ctrl.rd_addr];
      rd_dly_r  <= dly_r[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.dly_clear) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        dly_r[i] <= '0;
      end
    end else if (ctrl.dly_push) begin
      dly_r[0] <= push_data;
      for (int i = 1; i < MAX_TAPS; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign rd_coef = rd_coef_r;
  assign rd_dly  = rd_dly_r;

endmodule

### hw/rtl/tnsf_mac.sv
module tnsf_mac
  import tnsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  acc_clr,
  input  logic  in_v,
  input  word_t dly,
  input  word_t coef,
  output logic  busy,
  output word_t acc
);

  logic signed [2*DATA_W-1:0] prod_r;
  logic                       prod_v_r;
  word_t                      acc_r;
  logic signed [DATA_W+1:0]   sum;

  always_ff @(posedge clk) begin
    if (in_v) begin
      prod_r <= dly * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= in_v;
    end
  end

  // high word of the product is floor(d*c / 2^32)
  assign sum = {{2{acc_r[DATA_W-1]}}, acc_r}
             + {{2{prod_r[2*DATA_W-1]}}, prod_r[2*DATA_W-1:DATA_W]};

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= sat34(sum);
    end
  end

  assign busy = prod_v_r;
  assign acc  = acc_r;

endmodule

### hw/rtl/tns_all_pole_spectral_filter.sv
// All-pole spectral noise shaping filter.
// Input channel (in_valid / in_stall): each word is either a coefficient load
// (in_operation = 0, tap in_coef_index 1..20, value in_coef_value) or a sample
// to filter (in_operation = 1, in_sample, in_start_of_run clears the history).
// Loads return no result; indexes outside 1..20 are
// dropped. Each filtered sample gives one word on the output channel
// (out_valid / out_stall), out_filtered_sample.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): 0 filter order,
// 1 state shift, 2 spectrum scale; other indexes are ignored. cfg_ready is
// always high; write only while the block is idle.
// Flow: an accepted sample walks its taps, then passes a subtract and a final
// state until its result is in the output register, and the next word can be
// taken once it is there; one shared 32x32 multiply-accumulate walks the taps,
// one tap per cycle, with a read and a product stage in front.
// in_stall stays high while a sample is in work.
// A stalled result holds in the output register; the next word is still taken,
// and the following result waits for that register to empty.
// Reset clears the history, configuration registers and handshake state;
// coefficients must be loaded before use.
module tns_all_pole_spectral_filter
  import tnsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [TAP_W-1:0]     in_coef_index,
  input  word_t                in_coef_value,
  input  word_t                in_sample,
  input  logic                 in_start_of_run,
  output logic                 out_valid,
  input  logic                 out_stall,
  output word_t                out_filtered_sample,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SH_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_SUB  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [SH_W-1:0] order_r, shift_r, scale_r;
  logic [TAP_W-1:0] k_r, k_nxt;
  logic            rd_v_r;
  word_t           y_r;
  logic            out_valid_r;
  word_t           out_data_r;

  logic            in_acc, filt_acc, load_acc, out_free, out_load, issue;
  logic [TAP_W-1:0] order_eff;
  tap_ctrl_t       tctrl;
  word_t           rd_coef, rd_dly, acc, push_data;
  logic            mac_busy;
  logic signed [DATA_W+1:0] diff;
  word_t           acc2;

  assign in_acc   = in_valid && !in_stall;
  assign filt_acc = in_acc && (in_operation == OP_FILTER);
  assign load_acc = in_acc && (in_operation == OP_LOAD);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_FIN) && out_free;
  assign issue    = (state_r == S_MAC) && (k_r != '0);

  assign order_eff = (TAP_W'(order_r) > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS)
                                                          : TAP_W'(order_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      shift_r <= '0;
      scale_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER: order_r <= cfg_data;
        REG_SHIFT: shift_r <= cfg_data;
        REG_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (filt_acc) begin
          state_nxt = S_MAC;
          k_nxt     = order_eff;
        end
      end
      S_MAC: begin
        if (issue) begin
          k_nxt = k_r - 1'b1;
        end else if (!rd_v_r && !mac_busy) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      rd_v_r  <= issue;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  assign acc2 = sat34({{2{acc[DATA_W-1]}}, acc} <<< 1);
  assign diff = {{2{y_r[DATA_W-1]}}, y_r} - {{2{acc2[DATA_W-1]}}, acc2};

  always_ff @(posedge clk) begin
    if (filt_acc) begin
      y_r <= shl_sat(in_sample, scale_r);
    end else if (state_r == S_SUB) begin
      y_r <= sat34(diff);
    end
  end

  assign push_data = shl_sat(y_r, shift_r);

  always_comb begin
    tctrl.coef_we    = load_acc && (in_coef_index != '0)
                       && (in_coef_index <= TAP_W'(MAX_TAPS));
    tctrl.coef_waddr = ADDR_W'(in_coef_index - 1'b1);
    tctrl.rd_en      = issue;
    tctrl.rd_addr    = ADDR_W'(k_r - 1'b1);
    tctrl.dly_clear  = filt_acc && in_start_of_run;
    tctrl.dly_push   = out_load;
  end

  tnsf_taps u_taps (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (tctrl),
    .coef_wdata (in_coef_value),
    .push_data  (push_data),
    .rd_coef    (rd_coef),
    .rd_dly     (rd_dly)
  );

  tnsf_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_clr (filt_acc),
    .in_v    (rd_v_r),
    .dly     (rd_dly),
    .coef    (rd_coef),
    .busy    (mac_busy),
    .acc     (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y_r >>> scale_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_data_r;

  a_filt_starts: assert property (@(posedge clk) disable iff (!rst_n)
    filt_acc |=> (state_r == S_MAC))
    else $error("filter word did not start the tap walk");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= TAP_W'(MAX_TAPS))
    else $error("tap counter out of range");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rd_v_r && !mac_busy))
    else $error("tap pipeline active while idle");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && $past(state_r) == S_FIN))
    else $error("finished sample not presented");

endmodule
